// ----- sv/timed_message_queue_assert.svh -----
// Assertion macros for the timed message queue checker.
// Expects signals named clk and rst_n in the including scope.
`ifndef TIMED_MESSAGE_QUEUE_ASSERT_SVH
`define TIMED_MESSAGE_QUEUE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define TMQ_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("timed_message_queue: assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define TMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timed_message_queue: assertion failed");

`endif

// ----- sv/tmq_pkg.sv -----
// Shared types and constants for the timed message queue.
// No dependencies; imported by controller, datapath, top level and checker.
package tmq_pkg;

  localparam int TIME_W    = 48;
  localparam int HANDLE_W  = 16;
  localparam int MODE_W    = 2;
  localparam int KIND_W    = 3;
  localparam int CNT_OUT_W = 5;

  localparam int MAX_DISPATCH = 16;
  localparam int DISP_W       = $clog2(MAX_DISPATCH + 1);

  localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SERVICE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DISPATCH  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_INS_OK    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INS_FULL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WAITING   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FLUSHED   = 3'd5;

  typedef struct packed {
    logic              load;
    logic              insert;
    logic              pop;
    logic              flush;
    logic              emit;
    logic [KIND_W-1:0] kind;
    logic              last;
  } dp_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              head_due;
    logic              out_free;
  } dp_sts_t;

endpackage

// ----- sv/timed_message_queue.sv -----
// Timed message queue: keeps up to QUEUE_DEPTH (handle, due time) entries
// sorted by due time in a shift register array, equal times in arrival order.
// An insert or flush is accepted into the input latch; then an insert shifts
// the array, or a flush clears the count, as the result is loaded. A service
// dispatches at most 16 entries, one result a cycle unless stalled, closing
// with a waiting or empty result. Each result waits in the output register
// while out_stall is high; the next item is taken once the last result of
// the current one is loaded. An unused mode code gives no result.
module timed_message_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tmq_pkg::MODE_W-1:0]      in_mode,
  input  logic [tmq_pkg::TIME_W-1:0]      in_due_time,
  input  logic [tmq_pkg::HANDLE_W-1:0]    in_msg_handle,
  input  logic [tmq_pkg::TIME_W-1:0]      in_now_time,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tmq_pkg::KIND_W-1:0]      out_kind,
  output logic [tmq_pkg::HANDLE_W-1:0]    out_handle,
  output logic [tmq_pkg::TIME_W-1:0]      out_wait_time,
  output logic [tmq_pkg::CNT_OUT_W-1:0]   out_pending_count,
  output logic                            out_last
);
  import tmq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tmq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_mode           (in_mode),
    .in_due_time       (in_due_time),
    .in_msg_handle     (in_msg_handle),
    .in_now_time       (in_now_time),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_handle        (out_handle),
    .out_wait_time     (out_wait_time),
    .out_pending_count (out_pending_count),
    .out_last          (out_last)
  );

endmodule

// ----- sv/tmq_ctrl.sv -----
// Controller state machine for the timed message queue.
// Depends on tmq_pkg; drives tmq_dp through dp_cmd_t and reads dp_sts_t.
module tmq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tmq_pkg::dp_sts_t  sts,
  output tmq_pkg::dp_cmd_t  cmd
);
  import tmq_pkg::*;

  typedef enum logic {ST_IDLE, ST_EXEC} state_t;

  localparam logic [DISP_W-1:0] DISP_CAP = DISP_W'(MAX_DISPATCH);

  state_t            state_r, state_nxt;
  logic [DISP_W-1:0] disp_cnt_r, disp_cnt_nxt;
  logic              accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    disp_cnt_nxt = disp_cnt_r;
    cmd          = '0;
    cmd.load     = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt    = ST_EXEC;
          disp_cnt_nxt = '0;
        end
      end
      ST_EXEC: begin
        case (sts.mode)
          MODE_INSERT: begin
            if (sts.out_free) begin
              cmd.emit   = 1'b1;
              cmd.last   = 1'b1;
              cmd.insert = !sts.full;
              cmd.kind   = sts.full ? KIND_INS_FULL : KIND_INS_OK;
              state_nxt  = ST_IDLE;
            end
          end
          MODE_SERVICE: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              if (!sts.empty && sts.head_due && (disp_cnt_r != DISP_CAP)) begin
                cmd.pop      = 1'b1;
                cmd.kind     = KIND_DISPATCH;
                disp_cnt_nxt = disp_cnt_r + 1'b1;
              end else begin
                cmd.last  = 1'b1;
                cmd.kind  = sts.empty ? KIND_EMPTY : KIND_WAITING;
                state_nxt = ST_IDLE;
              end
            end
          end
          MODE_FLUSH: begin
            if (sts.out_free) begin
              cmd.emit  = 1'b1;
              cmd.last  = 1'b1;
              cmd.flush = 1'b1;
              cmd.kind  = KIND_FLUSHED;
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      disp_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      disp_cnt_r <= disp_cnt_nxt;
    end
  end

endmodule

// ----- sv/tmq_dp.sv -----
// Datapath for the timed message queue: input latch, sorted shift array,
// entry count and result register. Depends on tmq_pkg; commanded by tmq_ctrl.
module tmq_dp #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tmq_pkg::MODE_W-1:0]      in_mode,
  input  logic [tmq_pkg::TIME_W-1:0]      in_due_time,
  input  logic [tmq_pkg::HANDLE_W-1:0]    in_msg_handle,
  input  logic [tmq_pkg::TIME_W-1:0]      in_now_time,
  input  tmq_pkg::dp_cmd_t                cmd,
  output tmq_pkg::dp_sts_t                sts,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tmq_pkg::KIND_W-1:0]      out_kind,
  output logic [tmq_pkg::HANDLE_W-1:0]    out_handle,
  output logic [tmq_pkg::TIME_W-1:0]      out_wait_time,
  output logic [tmq_pkg::CNT_OUT_W-1:0]   out_pending_count,
  output logic                            out_last
);
  import tmq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int XW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;
  localparam logic [XW-1:0] CNT_SAT = XW'((1 << CNT_OUT_W) - 1);

  logic [MODE_W-1:0]   mode_r;
  logic [TIME_W-1:0]   due_r;
  logic [HANDLE_W-1:0] hdl_r;
  logic [TIME_W-1:0]   now_r;

  logic [TIME_W-1:0]   due_q_r [QUEUE_DEPTH];
  logic [HANDLE_W-1:0] hdl_q_r [QUEUE_DEPTH];
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [QUEUE_DEPTH-1:0] le_vec;

  logic                 out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]    out_kind_r;
  logic [HANDLE_W-1:0]  out_handle_r;
  logic [TIME_W-1:0]    out_wait_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;
  logic                 out_last_r;

  logic [XW-1:0]        cnt_x;
  logic [CNT_OUT_W-1:0] cnt_sat;
  logic                 head_due;
  logic [TIME_W-1:0]    wait_val;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      due_r  <= in_due_time;
      hdl_r  <= in_msg_handle;
      now_r  <= in_now_time;
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      le_vec[i] = (CW'(i) < cnt_r) && (due_q_r[i] <= due_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (!le_vec[0]) begin
        due_q_r[0] <= due_r;
        hdl_q_r[0] <= hdl_r;
      end
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (!le_vec[i]) begin
          if (le_vec[i-1]) begin
            due_q_r[i] <= due_r;
            hdl_q_r[i] <= hdl_r;
          end else begin
            due_q_r[i] <= due_q_r[i-1];
            hdl_q_r[i] <= hdl_q_r[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        due_q_r[i] <= due_q_r[i+1];
        hdl_q_r[i] <= hdl_q_r[i+1];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.flush) begin
      cnt_nxt = '0;
    end else if (cmd.insert) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (cmd.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_due = (now_r >= due_q_r[0]);
  assign wait_val = head_due ? '0 : (due_q_r[0] - now_r);
  assign cnt_x    = XW'(cnt_nxt);
  assign cnt_sat  = (cnt_x > CNT_SAT) ? CNT_OUT_W'(CNT_SAT) : CNT_OUT_W'(cnt_x);

  assign sts.mode     = mode_r;
  assign sts.full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign sts.empty    = (cnt_r == '0);
  assign sts.head_due = head_due;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind_r   <= cmd.kind;
      out_handle_r <= (cmd.kind == KIND_DISPATCH) ? hdl_q_r[0] : '0;
      out_wait_r   <= (cmd.kind == KIND_WAITING) ? wait_val : '0;
      out_cnt_r    <= cnt_sat;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_handle        = out_handle_r;
  assign out_wait_time     = out_wait_r;
  assign out_pending_count = out_cnt_r;
  assign out_last          = out_last_r;

endmodule

// ----- sv/tmq_chk.sv -----
// Port-level checker for the timed message queue, bound to the top level.
// Depends on tmq_pkg and timed_message_queue_assert.svh.
module tmq_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [tmq_pkg::KIND_W-1:0]      out_kind,
  input logic [tmq_pkg::HANDLE_W-1:0]    out_handle,
  input logic [tmq_pkg::TIME_W-1:0]      out_wait_time,
  input logic [tmq_pkg::CNT_OUT_W-1:0]   out_pending_count,
  input logic                            out_last
);
  import tmq_pkg::*;
  `include "timed_message_queue_assert.svh"

  `TMQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_kind) && $stable(out_handle) && $stable(out_pending_count) && $stable(out_last))
  `TMQ_ASSERT_ALWAYS(a_handle_zero, !out_valid || (out_kind == KIND_DISPATCH) || (out_handle == '0))
  `TMQ_ASSERT_ALWAYS(a_wait_zero, !out_valid || (out_kind == KIND_WAITING) || (out_wait_time == '0))
  `TMQ_ASSERT_ALWAYS(a_last_kind, !out_valid || ((out_kind == KIND_DISPATCH) != out_last))
  `TMQ_ASSERT_ALWAYS(a_cleared_cnt, !out_valid || ((out_kind != KIND_FLUSHED) && (out_kind != KIND_EMPTY)) || (out_pending_count == '0))

endmodule

bind timed_message_queue tmq_chk u_tmq_chk (.*);
